>>> design/nalsplit_pkg.sv
// ----------------------------------------------------------------------------
// nalsplit_pkg
// Shared types and constants of the Annex B NAL unit splitter.
// ----------------------------------------------------------------------------
package nalsplit_pkg;

  localparam int POSITION_WIDTH_DEF = 32;
  localparam int LENGTH_WIDTH_DEF   = 24;
  localparam int QUEUE_DEPTH_DEF    = 4;
  localparam int CFG_WIDTH          = 24;

  localparam logic [CFG_WIDTH-1:0] MAX_LEN_RESET = 24'd100000;

  localparam logic [7:0] START_CODE_BYTE = 8'h01;

  localparam logic [7:0] HDR_FORBIDDEN_MASK = 8'h80;
  localparam logic [7:0] HDR_REF_IDC_MASK   = 8'h60;
  localparam logic [7:0] HDR_TYPE_MASK      = 8'h1f;

  localparam logic [2:0] PREFIX_THREE = 3'd3;
  localparam logic [2:0] PREFIX_FOUR  = 3'd4;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_STRAY    = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_OVERSIZE = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [31:0] unit_offset;
    logic [23:0] unit_length;
    logic [2:0]  prefix_length;
    logic        hdr_forbidden;
    logic [1:0]  ref_idc;
    logic [4:0]  unit_type;
    status_t     status;
    logic        last_record;
  } out_t;

endpackage

>>> design/nalsplit_front.sv
// ----------------------------------------------------------------------------
// nalsplit_front
// Start code detection and unit bookkeeping; queues up to two unit closures
// per accepted byte.
// ----------------------------------------------------------------------------
module nalsplit_front #(
  parameter  int POSITION_WIDTH = nalsplit_pkg::POSITION_WIDTH_DEF,
  parameter  int LENGTH_WIDTH   = nalsplit_pkg::LENGTH_WIDTH_DEF,
  localparam int EV_W           = POSITION_WIDTH + LENGTH_WIDTH + 13
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  nalsplit_pkg::in_t  in_data,
  input  logic               q_space_ok,
  output logic [1:0]         wr_cnt,
  output logic [EV_W-1:0]    wr_data0,
  output logic [EV_W-1:0]    wr_data1
);

  localparam int CW = LENGTH_WIDTH + 1;

  typedef struct packed {
    logic [POSITION_WIDTH-1:0] offset;
    logic [CW-1:0]             count;
    logic                      four;
    logic [7:0]                header;
    logic                      last;
    logic                      stray;
    logic                      hunt;
  } ev_t;

  logic [23:0]               recent_r, recent_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic [POSITION_WIDTH-1:0] start_r, start_m, start_nxt;
  logic                      four_r, four_m, four_nxt;
  logic [CW-1:0]             bytes_r, bytes_m, bytes_nxt;
  logic [7:0]                header_r, header_m, header_nxt;
  logic                      inside_r, inside_m, inside_nxt;
  logic                      stray_r, stray_m, stray_nxt;

  logic          accept;
  logic [7:0]    b;
  logic          eos;
  logic          sc;
  logic          sc_four;
  logic [CW-1:0] zeros;
  logic [CW-1:0] n_sc;
  logic          v0;
  ev_t           ev0;
  ev_t           ev1;

  assign in_stall = !q_space_ok;
  assign accept   = in_valid && q_space_ok;

  always_comb begin
    b       = in_data.data_byte;
    eos     = in_data.end_of_stream;
    sc      = (recent_r[15:0] == 16'h0000) && (b == nalsplit_pkg::START_CODE_BYTE);
    sc_four = (recent_r == 24'h000000);
    zeros   = sc_four ? CW'(3) : CW'(2);
    n_sc    = (bytes_r >= zeros) ? (bytes_r - zeros) : '0;

    inside_m = inside_r;
    four_m   = four_r;
    start_m  = start_r;
    bytes_m  = bytes_r;
    header_m = header_r;
    stray_m  = stray_r;
    if (sc) begin
      inside_m = 1'b1;
      four_m   = sc_four;
      start_m  = pos_r - (sc_four ? POSITION_WIDTH'(3) : POSITION_WIDTH'(2));
      bytes_m  = '0;
      header_m = 8'h00;
      // The first unit's closure clears the stray mark; while hunting, bytes
      // ahead of the start code set it.
      stray_m  = inside_r ? 1'b0 : (stray_r || (n_sc != '0));
    end else begin
      if (inside_r && (bytes_r == '0)) begin
        header_m = b;
      end
      if (!(&bytes_r)) begin
        bytes_m = bytes_r + CW'(1);
      end
    end

    v0         = sc && inside_r;
    ev0.offset = start_r;
    ev0.count  = n_sc;
    ev0.four   = four_r;
    ev0.header = header_r;
    ev0.last   = 1'b0;
    ev0.stray  = stray_r;
    ev0.hunt   = 1'b0;

    if (inside_m) begin
      ev1.offset = start_m;
      ev1.count  = bytes_m;
      ev1.four   = four_m;
      ev1.header = header_m;
      ev1.last   = 1'b1;
      ev1.stray  = stray_m;
      ev1.hunt   = 1'b0;
    end else begin
      ev1.offset = '0;
      ev1.count  = bytes_m;
      ev1.four   = 1'b0;
      ev1.header = 8'h00;
      ev1.last   = 1'b1;
      ev1.stray  = 1'b1;
      ev1.hunt   = 1'b1;
    end

    wr_cnt   = accept ? ({1'b0, v0} + {1'b0, eos}) : 2'd0;
    wr_data0 = v0 ? ev0 : ev1;
    wr_data1 = ev1;

    recent_nxt = {recent_r[15:0], b};
    pos_nxt    = pos_r + POSITION_WIDTH'(1);
    inside_nxt = inside_m;
    four_nxt   = four_m;
    start_nxt  = start_m;
    bytes_nxt  = bytes_m;
    header_nxt = header_m;
    stray_nxt  = stray_m;
    if (eos) begin
      recent_nxt = 24'hffffff;
      pos_nxt    = '0;
      inside_nxt = 1'b0;
      four_nxt   = 1'b0;
      start_nxt  = '0;
      bytes_nxt  = '0;
      header_nxt = 8'h00;
      stray_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= 24'hffffff;
      pos_r    <= '0;
      inside_r <= 1'b0;
      four_r   <= 1'b0;
      start_r  <= '0;
      bytes_r  <= '0;
      header_r <= 8'h00;
      stray_r  <= 1'b0;
    end else if (accept) begin
      recent_r <= recent_nxt;
      pos_r    <= pos_nxt;
      inside_r <= inside_nxt;
      four_r   <= four_nxt;
      start_r  <= start_nxt;
      bytes_r  <= bytes_nxt;
      header_r <= header_nxt;
      stray_r  <= stray_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_eos_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.end_of_stream |=> (pos_r == '0) && !inside_r && !stray_r)
    else $error("end of stream did not restart the stream state");
`endif

endmodule

>>> design/nalsplit_queue.sv
// ----------------------------------------------------------------------------
// nalsplit_queue
// Small register queue taking zero, one or two entries per cycle and
// giving zero or one.
// ----------------------------------------------------------------------------
module nalsplit_queue #(
  parameter int DATA_W = 69,
  parameter int DEPTH  = nalsplit_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        wr_cnt,
  input  logic [DATA_W-1:0] wr_data0,
  input  logic [DATA_W-1:0] wr_data1,
  output logic              space_ok,
  output logic              not_empty,
  input  logic              pop,
  output logic [DATA_W-1:0] rd_data
);

  // DEPTH must be a power of two so that the pointers wrap by themselves; nothing here checks it.
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  always_comb begin
    wptr_nxt  = wptr_r + PTR_W'(wr_cnt);
    rptr_nxt  = rptr_r + PTR_W'(pop);
    count_nxt = count_r + CNT_W'(wr_cnt) - CNT_W'(pop);
    space_ok  = (count_r <= CNT_W'(DEPTH - 2));
    not_empty = (count_r != '0);
    rd_data   = mem[rptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      mem[wptr_r] <= wr_data0;
    end
    if (wr_cnt == 2'd2) begin
      mem[wptr_r + PTR_W'(1)] <= wr_data1;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond its depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue read while empty");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_cnt != 2'd0) |-> ((count_r + CNT_W'(wr_cnt)) <= CNT_W'(DEPTH) + CNT_W'(pop)))
    else $error("queue written beyond its depth");
`endif

endmodule

>>> design/nalsplit_back.sv
// ----------------------------------------------------------------------------
// nalsplit_back
// Turns queued unit closures into result records: status, saturation,
// header fields, and the output register.
// ----------------------------------------------------------------------------
module nalsplit_back #(
  parameter  int POSITION_WIDTH = nalsplit_pkg::POSITION_WIDTH_DEF,
  parameter  int LENGTH_WIDTH   = nalsplit_pkg::LENGTH_WIDTH_DEF,
  localparam int EV_W           = POSITION_WIDTH + LENGTH_WIDTH + 13
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  logic [EV_W-1:0]                     q_data,
  output logic                                q_pop,
  input  logic [nalsplit_pkg::CFG_WIDTH-1:0]  max_len,
  output logic                                out_valid,
  input  logic                                out_stall,
  output nalsplit_pkg::out_t                  out_data
);

  localparam int CW   = LENGTH_WIDTH + 1;
  localparam int CMPW = (CW > nalsplit_pkg::CFG_WIDTH) ? CW : nalsplit_pkg::CFG_WIDTH;

  typedef struct packed {
    logic [POSITION_WIDTH-1:0] offset;
    logic [CW-1:0]             count;
    logic                      four;
    logic [7:0]                header;
    logic                      last;
    logic                      stray;
    logic                      hunt;
  } ev_t;

  ev_t                     ev;
  logic                    over_field;
  logic                    too_big;
  logic                    empty;
  logic [LENGTH_WIDTH-1:0] sat_len;
  logic [7:0]              hdr;
  nalsplit_pkg::status_t   st;
  nalsplit_pkg::out_t      rec;

  logic                    out_valid_r;
  nalsplit_pkg::out_t      out_r;

  always_comb begin
    ev         = q_data;
    over_field = ev.count[LENGTH_WIDTH];
    sat_len    = over_field ? '1 : ev.count[LENGTH_WIDTH-1:0];
    too_big    = over_field || (CMPW'(ev.count) > CMPW'(max_len));
    empty      = (ev.count == '0);
    hdr        = empty ? 8'h00 : ev.header;

    if (ev.hunt) begin
      st = nalsplit_pkg::ST_STRAY;
    end else if (empty) begin
      st = nalsplit_pkg::ST_EMPTY;
    end else if (too_big) begin
      st = nalsplit_pkg::ST_OVERSIZE;
    end else if (ev.stray) begin
      st = nalsplit_pkg::ST_STRAY;
    end else begin
      st = nalsplit_pkg::ST_OK;
    end

    rec.unit_offset   = 32'(ev.offset);
    rec.unit_length   = 24'(sat_len);
    rec.prefix_length = ev.four ? nalsplit_pkg::PREFIX_FOUR : nalsplit_pkg::PREFIX_THREE;
    rec.hdr_forbidden = |(hdr & nalsplit_pkg::HDR_FORBIDDEN_MASK);
    rec.ref_idc       = 2'((hdr & nalsplit_pkg::HDR_REF_IDC_MASK) >> 5);
    rec.unit_type     = 5'(hdr & nalsplit_pkg::HDR_TYPE_MASK);
    rec.status        = st;
    rec.last_record   = ev.last;

    q_pop = q_valid && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= rec;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_empty_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status == nalsplit_pkg::ST_EMPTY) |->
      (out_r.unit_length == 24'd0) && (out_r.unit_type == 5'd0) && !out_r.last_record ||
      out_valid_r && (out_r.status == nalsplit_pkg::ST_EMPTY) &&
      (out_r.unit_length == 24'd0) && (out_r.unit_type == 5'd0))
    else $error("empty unit record carries a length or header");
`endif

endmodule

>>> design/annexb_nal_unit_splitter_core.sv
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter_core
// Splits an H.264 Annex B byte stream into NAL unit records.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_data) takes one stream byte
//   per transaction, with end_of_stream set on the final byte. The result
//   channel (out_valid, out_stall, out_data) gives one record per closed NAL
//   unit, plus one stray record at end of stream if no unit is open. The
//   configuration channel (cfg_valid, cfg_ready, cfg_data) writes
//   max_unit_length; it is always ready and is to be written only while
//   idle, which the block itself does not enforce. Throughput is one byte
//   per cycle while in_stall is low. A byte closes at most two units (a start
//   code that is also the final byte), and those two records leave the queue
//   one per cycle while out_stall is low. Each record is written into the queue
//   when the byte closing it is taken, then popped into the output register.
//   When the receiver stalls, records pile up in a four-entry queue; in_stall
//   rises once fewer than two entries are free, so no record is ever lost.
//   Reset empties the queue and the output register, returns the parser to
//   hunting for the first start code at position zero and loads max_unit_length
//   with 100000. End of stream does the same to the parser but keeps the register.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter_core #(
  parameter int POSITION_WIDTH = nalsplit_pkg::POSITION_WIDTH_DEF,
  parameter int LENGTH_WIDTH   = nalsplit_pkg::LENGTH_WIDTH_DEF,
  parameter int QUEUE_DEPTH    = nalsplit_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  nalsplit_pkg::in_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output nalsplit_pkg::out_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [nalsplit_pkg::CFG_WIDTH-1:0] cfg_data
);

  // One queued closure: offset, count, prefix flag, header and three flags.
  localparam int EV_W = POSITION_WIDTH + LENGTH_WIDTH + 13;

  logic [nalsplit_pkg::CFG_WIDTH-1:0] max_len_r;

  logic [1:0]      wr_cnt;
  logic [EV_W-1:0] wr_data0;
  logic [EV_W-1:0] wr_data1;
  logic            q_space_ok;
  logic            q_not_empty;
  logic            q_pop;
  logic [EV_W-1:0] q_data;

  // The register port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= nalsplit_pkg::MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_data;
    end
  end

  // Front end: start code search and unit bookkeeping, one byte a cycle while the queue has room.
  nalsplit_front #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .LENGTH_WIDTH   (LENGTH_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_space_ok (q_space_ok),
    .wr_cnt     (wr_cnt),
    .wr_data0   (wr_data0),
    .wr_data1   (wr_data1)
  );

  // Queue between the two halves, so each side can stall on its own.
  nalsplit_queue #(
    .DATA_W (EV_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_cnt    (wr_cnt),
    .wr_data0  (wr_data0),
    .wr_data1  (wr_data1),
    .space_ok  (q_space_ok),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .rd_data   (q_data)
  );

  // Back end: status, saturation and the output register.
  nalsplit_back #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .LENGTH_WIDTH   (LENGTH_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .max_len   (max_len_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled while no record is waiting at the output");
`endif

endmodule
